/* hdl/sha_pkg.sv */
package sha_pkg;

    localparam int BLOCK_BITS = 512;
    localparam int WORD_BITS  = 32;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [6:0] LENGTH_AT = 7'd56;
    localparam logic [6:0] LAST_POS  = 7'd63;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } round_vars_t;

    typedef struct packed {
        logic        use_block;
        logic [31:0] k;
    } round_ctl_t;

    localparam round_vars_t H_INIT = '{
        a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
        e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

endpackage

/* hdl/sha256_hash_engine_unit.sv */
// Channel   Handshake              Payload                              Width
// -------   --------------------   ----------------------------------   ---------
// input     in_valid / in_ready    data_byte, has_byte, end_of_message  8 / 1 / 1
// output    out_valid / out_ready  digest_word, word_index, last_word   32 / 3 / 1
//
// A byte that completes a 64-byte block starts compression: the single round unit
// runs one round a cycle, then S_UPDATE adds the result into the hash words.
// End of message: padding bytes are written up to the block end (64 - fill of
// them), then the block is compressed, twice when more than 55 bytes are pending,
// then eight output transactions.
// Reset loads the initial hash words and clears counts; block data needs none.
// in_ready is low while a full block is compressed, and from end of message until
// the last digest word is taken; the output side holds each word until out_ready.
module sha256_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PAD    = 5'b00010,
        S_ROUND  = 5'b00100,
        S_UPDATE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [6:0]                   fill_reg, fill_next;
    logic [63:0]                  bits_reg, bits_next;
    logic [5:0]                   round_reg, round_next;
    logic [2:0]                   idx_reg, idx_next;
    logic                         eom_reg, eom_next;       // padding owed for this message
    logic                         mark_reg, mark_next;     // 0x80 not yet written
    logic                         len_ok_reg, len_ok_next; // length goes in this block
    logic                         last_blk_reg, last_blk_next;
    sha_pkg::round_vars_t         hash_reg, hash_next;
    sha_pkg::round_vars_t         vars_reg, vars_next;
    logic [sha_pkg::BLOCK_BITS-1:0] win_reg, win_next;

    sha_pkg::round_ctl_t          ctl;
    sha_pkg::round_vars_t         vars_round;
    logic [31:0]                  sched_word;
    logic [7:0]                   pad_byte;
    logic                         in_fire;
    logic                         out_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign ctl.use_block = (round_reg[5:4] == 2'b00);
    assign ctl.k         = sha_pkg::round_k(round_reg);

    sha_round u_round (
        .vars_in    (vars_reg),
        .window     (win_reg),
        .ctl        (ctl),
        .vars_out   (vars_round),
        .sched_word (sched_word)
    );

    // Padding byte for the current slot: mark first, length in the final block.
    always_comb
    begin
        if (mark_reg)
        begin
            pad_byte = sha_pkg::PAD_MARK;
        end
        else if (len_ok_reg && (fill_reg >= sha_pkg::LENGTH_AT))
        begin
            pad_byte = bits_reg[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        case (idx_reg)
            3'd0:    digest_word = hash_reg.a;
            3'd1:    digest_word = hash_reg.b;
            3'd2:    digest_word = hash_reg.c;
            3'd3:    digest_word = hash_reg.d;
            3'd4:    digest_word = hash_reg.e;
            3'd5:    digest_word = hash_reg.f;
            3'd6:    digest_word = hash_reg.g;
            3'd7:    digest_word = hash_reg.h;
            default: digest_word = hash_reg.a;
        endcase
    end

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd7);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        eom_next      = eom_reg;
        mark_next     = mark_reg;
        len_ok_next   = len_ok_reg;
        last_blk_next = last_blk_reg;
        hash_next     = hash_reg;
        vars_next     = vars_reg;
        win_next      = win_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    eom_next  = end_of_message;
                    mark_next = end_of_message;
                    if (has_byte)
                    begin
                        // shift the byte into the block, oldest byte at the top
                        win_next  = {win_reg[sha_pkg::BLOCK_BITS-9:0], data_byte};
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_reg + 7'd1;
                    end
                    if (has_byte && (fill_reg == sha_pkg::LAST_POS))
                    begin
                        fill_next     = 7'd0;
                        last_blk_next = 1'b0;
                        round_next    = 6'd0;
                        vars_next     = hash_reg;
                        state_next    = S_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                win_next  = {win_reg[sha_pkg::BLOCK_BITS-9:0], pad_byte};
                fill_next = fill_reg + 7'd1;
                if (mark_reg)
                begin
                    mark_next   = 1'b0;
                    len_ok_next = (fill_reg < sha_pkg::LENGTH_AT);
                end
                else if (len_ok_reg && (fill_reg >= sha_pkg::LENGTH_AT))
                begin
                    // drop the length byte just sent; the count ends at zero
                    bits_next = {bits_reg[55:0], 8'h00};
                end
                if (fill_reg == sha_pkg::LAST_POS)
                begin
                    fill_next     = 7'd0;
                    last_blk_next = !mark_reg && len_ok_reg;
                    round_next    = 6'd0;
                    vars_next     = hash_reg;
                    state_next    = S_ROUND;
                end
            end

            S_ROUND:
            begin
                vars_next  = vars_round;
                win_next   = {win_reg[sha_pkg::BLOCK_BITS-33:0], sched_word};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                hash_next.a = hash_reg.a + vars_reg.a;
                hash_next.b = hash_reg.b + vars_reg.b;
                hash_next.c = hash_reg.c + vars_reg.c;
                hash_next.d = hash_reg.d + vars_reg.d;
                hash_next.e = hash_reg.e + vars_reg.e;
                hash_next.f = hash_reg.f + vars_reg.f;
                hash_next.g = hash_reg.g + vars_reg.g;
                hash_next.h = hash_reg.h + vars_reg.h;
                if (!eom_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (last_blk_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = S_OUT;
                end
                else
                begin
                    // spill block done: the length now fits in the next one
                    len_ok_next = 1'b1;
                    state_next  = S_PAD;
                end
            end

            S_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        hash_next  = sha_pkg::H_INIT;
                        bits_next  = 64'd0;
                        fill_next  = 7'd0;
                        eom_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= 7'd0;
            bits_reg     <= 64'd0;
            round_reg    <= 6'd0;
            idx_reg      <= 3'd0;
            eom_reg      <= 1'b0;
            mark_reg     <= 1'b0;
            len_ok_reg   <= 1'b0;
            last_blk_reg <= 1'b0;
            hash_reg     <= sha_pkg::H_INIT;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
            eom_reg      <= eom_next;
            mark_reg     <= mark_next;
            len_ok_reg   <= len_ok_next;
            last_blk_reg <= last_blk_next;
            hash_reg     <= hash_next;
        end
    end

    // Block window and working variables: written before they are read.
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
    end

endmodule

/* hdl/sha_round.sv */
// One compression round plus the matching message schedule word.
module sha_round (
    input  sha_pkg::round_vars_t            vars_in,
    input  logic [sha_pkg::BLOCK_BITS-1:0]  window,
    input  sha_pkg::round_ctl_t             ctl,
    output sha_pkg::round_vars_t            vars_out,
    output logic [sha_pkg::WORD_BITS-1:0]   sched_word
);

    logic [31:0] w_old;   // W[t-16], oldest word in the window
    logic [31:0] w_15;
    logic [31:0] w_7;
    logic [31:0] w_2;
    logic [31:0] sig0;
    logic [31:0] sig1;
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    assign w_old = window[511:480];
    assign w_15  = window[479:448];
    assign w_7   = window[223:192];
    assign w_2   = window[63:32];

    assign sig0 = sha_pkg::ror32(w_15, 5'd7) ^ sha_pkg::ror32(w_15, 5'd18) ^ (w_15 >> 3);
    assign sig1 = sha_pkg::ror32(w_2, 5'd17) ^ sha_pkg::ror32(w_2, 5'd19) ^ (w_2 >> 10);

    // First sixteen rounds take the block words as they stand.
    assign sched_word = ctl.use_block ? w_old : (sig1 + w_7 + sig0 + w_old);

    assign big1 = sha_pkg::ror32(vars_in.e, 5'd6) ^ sha_pkg::ror32(vars_in.e, 5'd11)
                ^ sha_pkg::ror32(vars_in.e, 5'd25);
    assign big0 = sha_pkg::ror32(vars_in.a, 5'd2) ^ sha_pkg::ror32(vars_in.a, 5'd13)
                ^ sha_pkg::ror32(vars_in.a, 5'd22);
    assign ch   = (vars_in.e & vars_in.f) ^ (~vars_in.e & vars_in.g);
    assign maj  = (vars_in.a & vars_in.b) ^ (vars_in.a & vars_in.c) ^ (vars_in.b & vars_in.c);
    assign t1   = vars_in.h + big1 + ch + ctl.k + sched_word;
    assign t2   = big0 + maj;

    always_comb
    begin
        vars_out.a = t1 + t2;
        vars_out.b = vars_in.a;
        vars_out.c = vars_in.b;
        vars_out.d = vars_in.c;
        vars_out.e = vars_in.d + t1;
        vars_out.f = vars_in.e;
        vars_out.g = vars_in.f;
        vars_out.h = vars_in.g;
    end

endmodule
